[design/tlvx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV tag extractor package
// Shared types, codes and constants of the TLV tag extractor.
// ----------------------------------------------------------------------------
package tlvx_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned TAG_W       = 16;
   localparam int unsigned LEN_W       = 15;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [BYTE_W-1:0] TAG_LONG_MASK = 8'h1F;
   localparam logic [BYTE_W-1:0] LEN_LONG_BIT  = 8'h80;
   localparam logic [BYTE_W-1:0] LEN_HIGH_MASK = 8'h7F;

   localparam logic [STATUS_W-1:0] ST_STREAM    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_TRUNC     = 2'd3;

   typedef enum logic [2:0] {
      PH_TAG1 = 3'd0,
      PH_TAG2 = 3'd1,
      PH_LEN1 = 3'd2,
      PH_LEN2 = 3'd3,
      PH_BODY = 3'd4
   } phase_type;

   typedef struct packed {
      logic [LEN_W-1:0]    value_length;
      logic [STATUS_W-1:0] status;
      logic                byte_valid;
      logic [BYTE_W-1:0]   value_byte;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } push_type;

endpackage

[design/tlvx_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV tag extractor front end
// Parses the TLV byte stream, holds the search tag and pushes results.
// ----------------------------------------------------------------------------
module tlvx_front
   import tlvx_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [TAG_W-1:0]  csr_tag,
   input  logic              byte_accept,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              end_of_message,
   output push_type          push
);

   logic [TAG_W-1:0] search_tag_ff, search_tag_in;
   phase_type        phase_ff, phase_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic             match_ff, match_in;
   logic             done_ff, done_in;

   logic [LEN_W-1:0] hdr_len;
   logic             hdr_end;
   logic             hdr_match;
   logic [LEN_W-1:0] left_dec;

   always_comb begin
      search_tag_in = csr_write ? csr_tag : search_tag_ff;
   end

   always_comb begin
      phase_in  = phase_ff;
      tag_in    = tag_ff;
      length_in = length_ff;
      left_in   = left_ff;
      match_in  = match_ff;
      done_in   = done_ff;
      push      = '0;
      hdr_len   = '0;
      hdr_end   = 1'b0;
      hdr_match = (tag_ff == search_tag_ff);
      left_dec  = (left_ff != '0) ? left_ff - LEN_W'(1) : left_ff;

      if (!done_ff) begin
         case (phase_ff)
            PH_TAG2: begin
               tag_in   = tag_ff | {{(TAG_W-BYTE_W){1'b0}}, data_byte};
               phase_in = PH_LEN1;
            end
            PH_LEN1: begin
               if ((data_byte & LEN_LONG_BIT) != '0) begin
                  length_in = {data_byte[6:0], {BYTE_W{1'b0}}};
                  phase_in  = PH_LEN2;
               end else begin
                  hdr_len = {{(LEN_W-BYTE_W){1'b0}}, data_byte};
                  hdr_end = 1'b1;
               end
            end
            PH_LEN2: begin
               hdr_len = {length_ff[LEN_W-1:BYTE_W], data_byte};
               hdr_end = 1'b1;
            end
            PH_BODY: begin
               left_in = left_dec;
               if (match_ff) begin
                  push.valid             = 1'b1;
                  push.result.value_byte = data_byte;
                  push.result.byte_valid = 1'b1;
                  push.result.status     = ST_STREAM;
                  if (left_dec == '0) begin
                     push.result.status       = ST_FOUND;
                     push.result.value_length = length_ff;
                     done_in                  = 1'b1;
                  end
               end else if (left_dec == '0) begin
                  phase_in = PH_TAG1;
               end
            end
            default: begin
               if ((data_byte & TAG_LONG_MASK) == TAG_LONG_MASK) begin
                  tag_in   = {data_byte, {(TAG_W-BYTE_W){1'b0}}};
                  phase_in = PH_TAG2;
               end else begin
                  tag_in   = {{(TAG_W-BYTE_W){1'b0}}, data_byte};
                  phase_in = PH_LEN1;
               end
            end
         endcase

         if (hdr_end) begin
            length_in = hdr_len;
            left_in   = hdr_len;
            match_in  = hdr_match;
            if (hdr_len == '0) begin
               phase_in = PH_TAG1;
               if (hdr_match) begin
                  done_in           = 1'b1;
                  push.valid        = 1'b1;
                  push.result       = '0;
                  push.result.status = ST_FOUND;
               end
            end else begin
               phase_in = PH_BODY;
            end
         end
      end

      if (end_of_message) begin
         if (!done_in) begin
            push.valid               = 1'b1;
            push.result.status       = (phase_in == PH_TAG1) ? ST_NOT_FOUND : ST_TRUNC;
            push.result.value_length = '0;
         end
         phase_in  = PH_TAG1;
         tag_in    = '0;
         length_in = '0;
         left_in   = '0;
         match_in  = 1'b0;
         done_in   = 1'b0;
      end

      if (!byte_accept) begin
         push.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_tag_ff <= '0;
         phase_ff      <= PH_TAG1;
         tag_ff        <= '0;
         length_ff     <= '0;
         left_ff       <= '0;
         match_ff      <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         search_tag_ff <= search_tag_in;
         if (byte_accept) begin
            phase_ff  <= phase_in;
            tag_ff    <= tag_in;
            length_ff <= length_in;
            left_ff   <= left_in;
            match_ff  <= match_in;
            done_ff   <= done_in;
         end
      end
   end

endmodule

[design/tlvx_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV tag extractor result queue
// Small result queue whose head drives the result channel.
// ----------------------------------------------------------------------------
module tlvx_queue
   import tlvx_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       space,
   output logic       head_valid,
   output result_type head,
   input  logic       head_pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   result_type       entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign space      = (count_ff != CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_pop     = head_valid && head_pop;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push.valid && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[design/tlv_stream_tag_extractor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV stream tag extractor
// Searches a TLV byte stream for one tag and streams out its value bytes.
// ----------------------------------------------------------------------------
// One message byte enters per req beat; req_tlast marks the last byte of a
// message. The user must write the tag to look for through the csr channel
// while idle; not enforced by the block. Each result goes into a small queue
// whose head drives the rsp channel: value bytes of the matched element with
// status streaming, then found with the value length on the last byte, or
// not found / truncated at the end of a message. Other bytes give no beat.
// A result is registered in the queue before it appears on rsp.
// The parser takes one byte per cycle; req_tready drops only when the
// result queue (QUEUE_DEPTH entries) is full, so a stalled receiver holds
// the input back after that many pending results and nothing is lost.
// Reset clears the parser, the queue and the search tag (tag zero).
// After the end of a message the parser restarts with the next byte.
// ----------------------------------------------------------------------------
module tlv_stream_tag_extractor
   import tlvx_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [TAG_W-1:0] csr_data,    // search_tag
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // data_byte
   input  logic             req_tlast,   // end_of_message
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [23:0]      rsp_tdata,   // value_byte, value_length, zero pad
   output logic [2:0]       rsp_tuser    // byte_valid, status
);

   push_type   push;
   logic       space;
   result_type head;

   assign csr_ready  = 1'b1;
   assign req_tready = space;

   tlvx_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_valid),
      .csr_tag        (csr_data),
      .byte_accept    (req_tvalid && space),
      .data_byte      (req_tdata),
      .end_of_message (req_tlast),
      .push           (push)
   );

   tlvx_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space      (space),
      .head_valid (rsp_tvalid),
      .head       (head),
      .head_pop   (rsp_tready)
   );

   assign rsp_tdata = {1'b0, head.value_length, head.value_byte};
   assign rsp_tuser = {head.status, head.byte_valid};

endmodule

[bench/tlv_stream_tag_extractor_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV stream tag extractor testbench
// A short table of hand-written beats comes first: the found, not found and
// truncated cases, an empty matched value, bytes after a match, and the
// largest tag with a long length. Random messages follow for several search tags.
// Every accepted byte passes through a local tracker of the parser, and
// every rsp beat is compared with the oldest result that the table or the
// tracker predicts. Both sides idle and stall at random, except in a calm stretch of the random messages.
// ----------------------------------------------------------------------------
module tlv_stream_tag_extractor_test;
   import tlvx_pkg::*;

   typedef enum logic {ROW_BYTE, ROW_TAG} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [15:0]  value;
      logic         last;
      bit           typed;
      bit           has;
      result_type   res;
   } row_type;

   logic             clock;
   logic             reset;
   logic             csr_valid;
   logic             csr_ready;
   logic [TAG_W-1:0] csr_data;
   logic             req_tvalid;
   logic             req_tready;
   logic [7:0]       req_tdata;
   logic             req_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [23:0]      rsp_tdata;
   logic [2:0]       rsp_tuser;

   logic [TAG_W-1:0] want_tag;
   phase_type        parse_phase;
   logic [TAG_W-1:0] tag_acc;
   logic [LEN_W-1:0] len_acc;
   logic [LEN_W-1:0] bytes_left;
   bit               tag_hit;
   bit               match_done;

   result_type       pending_results[$];
   result_type       head_result;
   row_type          directed_beats[$];
   logic [7:0]       message[$];
   bit               calm;
   int               errors;

   tlv_stream_tag_extractor i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   task automatic report_mismatch(input string field, input int got, input int want);
      errors++;
      if (errors <= 50) begin
         $display("mismatch at %0t ns: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
      end
   endtask

   function automatic void clear_parser();
      parse_phase = PH_TAG1;
      tag_acc     = '0;
      len_acc     = '0;
      bytes_left  = '0;
      tag_hit     = 1'b0;
      match_done  = 1'b0;
   endfunction

   function automatic bit close_header();
      tag_hit    = (tag_acc == want_tag);
      bytes_left = len_acc;
      if (len_acc == '0) begin
         parse_phase = PH_TAG1;
         if (tag_hit) begin
            match_done = 1'b1;
            return 1'b1;
         end
         return 1'b0;
      end
      parse_phase = PH_BODY;
      return 1'b0;
   endfunction

   task automatic track_byte(input logic [7:0] b, input logic last,
                             output bit has, output result_type r);
      has = 1'b0;
      r   = '0;
      if (!match_done) begin
         case (parse_phase)
            PH_TAG2: begin
               tag_acc     = tag_acc | {8'h00, b};
               parse_phase = PH_LEN1;
            end
            PH_LEN1: begin
               if ((b & LEN_LONG_BIT) != 8'h00) begin
                  len_acc     = {b[6:0], 8'h00};
                  parse_phase = PH_LEN2;
               end else begin
                  len_acc = {7'd0, b};
                  if (close_header()) begin
                     has      = 1'b1;
                     r.status = ST_FOUND;
                  end
               end
            end
            PH_LEN2: begin
               len_acc = len_acc | {7'd0, b};
               if (close_header()) begin
                  has      = 1'b1;
                  r.status = ST_FOUND;
               end
            end
            PH_BODY: begin
               if (bytes_left != '0) begin
                  bytes_left = bytes_left - LEN_W'(1);
               end
               if (tag_hit) begin
                  has          = 1'b1;
                  r.value_byte = b;
                  r.byte_valid = 1'b1;
                  r.status     = ST_STREAM;
                  if (bytes_left == '0) begin
                     r.status       = ST_FOUND;
                     r.value_length = len_acc;
                     match_done     = 1'b1;
                  end
               end else if (bytes_left == '0) begin
                  parse_phase = PH_TAG1;
               end
            end
            default: begin
               if ((b & TAG_LONG_MASK) == TAG_LONG_MASK) begin
                  tag_acc     = {b, 8'h00};
                  parse_phase = PH_TAG2;
               end else begin
                  tag_acc     = {8'h00, b};
                  parse_phase = PH_LEN1;
               end
            end
         endcase
      end
      if (last) begin
         if (!match_done) begin
            has            = 1'b1;
            r.status       = (parse_phase == PH_TAG1) ? ST_NOT_FOUND : ST_TRUNC;
            r.value_length = '0;
         end
         clear_parser();
      end
   endtask

   task automatic push_byte(input logic [7:0] b, input logic last, input bit typed,
                            input bit typed_has, input result_type typed_res);
      bit         has;
      result_type r;
      while (!calm && $urandom_range(99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      track_byte(b, last, has, r);
      if (typed) begin
         if (typed_has) begin
            pending_results.push_back(typed_res);
         end
      end else if (has) begin
         pending_results.push_back(r);
      end
   endtask

   task automatic write_tag(input logic [TAG_W-1:0] tag);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= tag;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      want_tag = tag;
   endtask

   task automatic build_message();
      int          len;
      int          cut;
      int          pick;
      logic [15:0] t;
      message.delete();
      if ($urandom_range(99) < 10) begin
         repeat ($urandom_range(8, 1)) message.push_back(8'($urandom));
         return;
      end
      repeat ($urandom_range(4, 1)) begin
         if ($urandom_range(99) < 40) begin
            t = want_tag;
         end else begin
            case ($urandom_range(2))
               0: t = {8'h00, 8'($urandom)};
               1: t = {8'($urandom) | TAG_LONG_MASK, 8'($urandom)};
               default: t = 16'($urandom);
            endcase
         end
         if (t[15:8] != 8'h00) begin
            message.push_back(t[15:8]);
         end
         message.push_back(t[7:0]);
         pick = $urandom_range(99);
         if (pick < 10) begin
            len = 0;
         end else if (pick < 85) begin
            len = $urandom_range(8, 1);
         end else begin
            len = $urandom_range(160, 9);
         end
         if (len < 128 && $urandom_range(1) == 0) begin
            message.push_back(8'(len));
         end else begin
            message.push_back(8'(len >> 8) | LEN_LONG_BIT);
            message.push_back(8'(len));
         end
         repeat (len) message.push_back(8'($urandom));
      end
      if ($urandom_range(99) < 15 && message.size() > 1) begin
         cut = $urandom_range(message.size() - 1, 1);
         while (message.size() > cut) begin
            message.pop_back();
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected rsp beat, tdata", rsp_tdata, 0);
         end else begin
            head_result = pending_results.pop_front();
            if (rsp_tdata[7:0] != head_result.value_byte) begin
               report_mismatch("value_byte", rsp_tdata[7:0], head_result.value_byte);
            end
            if (rsp_tdata[22:8] != head_result.value_length) begin
               report_mismatch("value_length", rsp_tdata[22:8], head_result.value_length);
            end
            if (rsp_tuser[0] != head_result.byte_valid) begin
               report_mismatch("byte_valid", rsp_tuser[0], head_result.byte_valid);
            end
            if (rsp_tuser[2:1] != head_result.status) begin
               report_mismatch("status", rsp_tuser[2:1], head_result.status);
            end
         end
      end
      rsp_tready <= calm || $urandom_range(99) >= 14;
   end

   initial begin
      #(64'd20_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int          random_items;
      int          phase_items;
      logic [15:0] next_tag;
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      calm       = 1'b0;
      errors     = 0;
      want_tag   = '0;
      clear_parser();

      directed_beats.push_back('{ROW_BYTE, 16'h0000, 1'b0, 1'b1, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h0000, 1'b0, 1'b1, 1'b1,
                                 result_type'{15'd0, ST_FOUND, 1'b0, 8'h00}});
      directed_beats.push_back('{ROW_BYTE, 16'h0055, 1'b1, 1'b1, 1'b0, '0});
      directed_beats.push_back('{ROW_TAG,  16'h9F21, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h009F, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h0021, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h0080, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h0003, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h0011, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h0022, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h0033, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h00FF, 1'b1, 1'b1, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h009F, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h0021, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h0002, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h0044, 1'b1, 1'b1, 1'b1,
                                 result_type'{15'd0, ST_TRUNC, 1'b1, 8'h44}});
      directed_beats.push_back('{ROW_BYTE, 16'h009F, 1'b1, 1'b1, 1'b1,
                                 result_type'{15'd0, ST_TRUNC, 1'b0, 8'h00}});
      directed_beats.push_back('{ROW_TAG,  16'hFFFF, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h00FF, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h00FF, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h00FF, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h00FF, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h0000, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h0080, 1'b1, 1'b1, 1'b1,
                                 result_type'{15'd0, ST_TRUNC, 1'b1, 8'h80}});
      directed_beats.push_back('{ROW_BYTE, 16'h0007, 1'b0, 1'b0, 1'b0, '0});
      directed_beats.push_back('{ROW_BYTE, 16'h0000, 1'b1, 1'b1, 1'b1,
                                 result_type'{15'd0, ST_NOT_FOUND, 1'b0, 8'h00}});

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_beats[i]) begin
         if (directed_beats[i].kind == ROW_TAG) begin
            write_tag(directed_beats[i].value);
         end else begin
            push_byte(directed_beats[i].value[7:0], directed_beats[i].last,
                      directed_beats[i].typed, directed_beats[i].has, directed_beats[i].res);
         end
      end

      random_items = 0;
      for (int p = 0; random_items < 1650; p++) begin
         case (p)
            0: next_tag = 16'h0000;
            1: next_tag = 16'hFFFF;
            default: begin
               case (p % 3)
                  0: begin
                     next_tag = {8'h00, 8'($urandom)};
                     if ((next_tag[7:0] & TAG_LONG_MASK) == TAG_LONG_MASK) begin
                        next_tag[0] = 1'b0;
                     end
                  end
                  1: next_tag = {8'($urandom) | TAG_LONG_MASK, 8'($urandom)};
                  default: next_tag = 16'($urandom);
               endcase
            end
         endcase
         write_tag(next_tag);
         phase_items = 0;
         while (phase_items < 200 && random_items < 1650) begin
            build_message();
            foreach (message[i]) begin
               calm = (random_items >= 700 && random_items < 1000);
               random_items++;
               phase_items++;
               push_byte(message[i], i == message.size() - 1, 1'b0, 1'b0, '0);
            end
         end
      end
      calm = 1'b0;

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
